FILE: hdl/ssmp_pkg.sv
package ssmp_pkg;

    localparam int MaxColumns = 64;
    localparam int CountBits  = 16;
    localparam int ColBits    = 6;
    localparam int LenBits    = 7;
    localparam int AccBits    = 48;
    localparam int ValBits    = 32;

    // Configuration register indexes.
    localparam logic [1:0] RegPoolMode   = 2'd0;
    localparam logic [1:0] RegRowLength  = 2'd1;
    localparam logic [1:0] RegPatchValue = 2'd2;

    localparam logic ActAccumulate = 1'b0;
    localparam logic ActClose      = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ELEM,
        ST_READ,
        ST_DIV,
        ST_OUT
    } t_state;

    // Request passed from the controller to the divider.
    typedef struct packed {
        logic                      start;
        logic signed [AccBits-1:0] dividend;
        logic [CountBits-1:0]      divisor;
    } t_div_req;

endpackage

FILE: hdl/ssmp_div.sv
module ssmp_div
    import ssmp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_div_req                  i_req,
    output logic                      o_done,
    output logic signed [AccBits-1:0] o_quot
);

    localparam int StepBits = $clog2(AccBits + 1);

    logic [AccBits-1:0]   r_rem, n_rem;
    logic [AccBits-1:0]   r_quo, n_quo;
    logic [CountBits-1:0] r_den, n_den;
    logic                 r_neg, n_neg;
    logic [StepBits-1:0]  r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [AccBits:0]     w_trial;
    logic [AccBits-1:0]   w_mag;

    assign w_mag = i_req.dividend[AccBits-1] ? AccBits'(-i_req.dividend)
                                             : AccBits'(i_req.dividend);
    assign w_trial = {r_rem, r_quo[AccBits-1]} - {{(AccBits+1-CountBits){1'b0}}, r_den};

    // Restoring division, one quotient bit a cycle on magnitudes.
    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_rem  = '0;
            n_quo  = w_mag;
            n_den  = i_req.divisor;
            n_neg  = i_req.dividend[AccBits-1];
            n_cnt  = StepBits'(AccBits);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[AccBits]) begin
                n_rem = w_trial[AccBits-1:0];
                n_quo = {r_quo[AccBits-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[AccBits-2:0], r_quo[AccBits-1]};
                n_quo = {r_quo[AccBits-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == StepBits'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
        r_neg <= n_neg;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

FILE: hdl/segment_sum_mean_pooling.sv
// Segment sum / mean pooling.
// Input channel (i_valid/o_ready) carries one beat per element or close.
// An element beat updates one column accumulator held in a synchronous
// memory: the entry is read at the accepting edge and the saturated sum is
// written back in the following cycle, so an element holds off the input
// until its write-back is done. An element on an out-of-range column is
// dropped at once and the input stays ready.
// A close beat emits one result beat per column of the effective row
// length on the output channel (o_valid/i_ready), in column order, with
// last_of_run on the final one. Each column passes a memory read state and
// an output state, with a bit-serial divide between them in mean mode.
// The output register holds its beat while the receiver stalls and the
// emission pauses until that beat is accepted. Once the last beat of a
// close sits in the register, new input is taken while it waits.
// Reset returns the configuration registers to their defaults and clears
// the row count; the accumulator memory needs no clearing.
// Configuration writes are taken at any time, intended only while idle.
module segment_sum_mean_pooling
    import ssmp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [31:0]               i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_action,
    input  logic signed [31:0]        i_element_value,
    input  logic [5:0]                i_column,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [31:0]        o_result_value,
    output logic [5:0]                o_result_column,
    output logic                      o_last_of_run,
    output logic                      o_empty_segment,
    output logic                      o_saturated
);

    localparam logic signed [AccBits-1:0] AccMax = {1'b0, {(AccBits-1){1'b1}}};
    localparam logic signed [AccBits-1:0] AccMin = {1'b1, {(AccBits-1){1'b0}}};
    localparam logic signed [AccBits-1:0] OutMax = AccBits'(64'sh7FFFFFFF);
    localparam logic signed [AccBits-1:0] OutMin = -AccBits'(64'sh80000000);

    logic                      r_pool_mode;
    logic [LenBits-1:0]        r_row_length;
    logic signed [31:0]        r_patch;
    logic [LenBits-1:0]        w_len;

    t_state                    r_state, n_state;
    logic [CountBits-1:0]      r_rows, n_rows;
    logic                      r_capped, n_capped;
    logic [ColBits-1:0]        r_col, n_col;
    logic signed [31:0]        r_elem;

    logic signed [AccBits-1:0] r_mem [MaxColumns];
    logic signed [AccBits-1:0] r_rd;
    logic                      w_we;
    logic signed [AccBits-1:0] w_wdata;
    logic signed [AccBits:0]   w_sum;

    logic                      r_ov, n_ov;
    logic signed [31:0]        r_val, n_val;
    logic                      r_last, n_last;
    logic                      r_empty, n_empty;
    logic                      r_sat, n_sat;
    logic [ColBits-1:0]        r_ocol, n_ocol;

    t_div_req                  w_req;
    logic                      w_div_done;
    logic signed [AccBits-1:0] w_quot;
    logic signed [AccBits-1:0] w_pick;
    logic                      w_accept;
    logic                      w_in_range;

    // Effective row length, 0 acts as 1 and larger values are clipped.
    always_comb begin
        if (r_row_length == '0) begin
            w_len = LenBits'(1);
        end else if (r_row_length > LenBits'(MaxColumns)) begin
            w_len = LenBits'(MaxColumns);
        end else begin
            w_len = r_row_length;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_mode  <= 1'b0;
            r_row_length <= LenBits'(64);
            r_patch      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                RegPoolMode:   r_pool_mode  <= i_cfg_data[0];
                RegRowLength:  r_row_length <= i_cfg_data[LenBits-1:0];
                RegPatchValue: r_patch      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_ready    = (r_state == ST_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_in_range = {1'b0, i_column} < w_len;

    // Accumulator read-modify-write with 48-bit saturation.
    assign w_sum = {r_rd[AccBits-1], r_rd} + (AccBits+1)'(r_elem);
    always_comb begin
        if (r_rows == '0) begin
            w_wdata = AccBits'(r_elem);
        end else if (w_sum > (AccBits+1)'(AccMax)) begin
            w_wdata = AccMax;
        end else if (w_sum < (AccBits+1)'(AccMin)) begin
            w_wdata = AccMin;
        end else begin
            w_wdata = w_sum[AccBits-1:0];
        end
    end
    assign w_we = (r_state == ST_ELEM);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_col] <= w_wdata;
        end
        r_rd <= r_mem[n_col];
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_elem <= i_element_value;
        end
    end

    // Next state and counters.
    always_comb begin
        n_state  = r_state;
        n_rows   = r_rows;
        n_capped = r_capped;
        n_col    = r_col;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_action == ActClose) begin
                        n_col   = '0;
                        n_state = ST_READ;
                    end else if (w_in_range) begin
                        n_col   = i_column;
                        n_state = ST_ELEM;
                    end
                end
            end
            ST_ELEM: begin
                if ({1'b0, r_col} == w_len - 1'b1) begin
                    if (&r_rows) begin
                        n_capped = 1'b1;
                    end else begin
                        n_rows = r_rows + 1'b1;
                    end
                end
                n_state = ST_IDLE;
            end
            ST_READ: begin
                if (r_pool_mode && r_rows != '0) begin
                    n_state = ST_DIV;
                end else if (!r_ov || i_ready) begin
                    n_state = ST_OUT;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_ov || i_ready) begin
                    if ({1'b0, r_col} == w_len - 1'b1) begin
                        n_rows   = '0;
                        n_capped = 1'b0;
                        n_state  = ST_IDLE;
                    end else begin
                        n_col   = r_col + 1'b1;
                        n_state = ST_READ;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_col <= n_col;
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rows   <= '0;
            r_capped <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rows   <= n_rows;
            r_capped <= n_capped;
        end
    end

    // Divider request for mean mode.
    always_comb begin
        w_req.start    = (r_state == ST_READ) && r_pool_mode && (r_rows != '0);
        w_req.dividend = r_rd;
        w_req.divisor  = r_rows;
    end

    ssmp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Output register: loaded in ST_OUT once the previous beat has gone.
    assign w_pick = r_pool_mode ? w_quot : r_rd;
    always_comb begin
        n_ov    = r_ov && !i_ready;
        n_val   = r_val;
        n_last  = r_last;
        n_empty = r_empty;
        n_sat   = r_sat;
        n_ocol  = r_ocol;
        if (r_state == ST_OUT && (!r_ov || i_ready)) begin
            n_ov    = 1'b1;
            n_ocol  = r_col;
            n_last  = ({1'b0, r_col} == w_len - 1'b1);
            n_empty = (r_rows == '0);
            if (r_rows == '0) begin
                n_val = r_patch;
                n_sat = 1'b0;
            end else if (w_pick > OutMax) begin
                n_val = 32'sh7FFFFFFF;
                n_sat = 1'b1;
            end else if (w_pick < OutMin) begin
                n_val = 32'sh80000000;
                n_sat = 1'b1;
            end else begin
                n_val = w_pick[31:0];
                n_sat = r_capped;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val   <= n_val;
        r_last  <= n_last;
        r_empty <= n_empty;
        r_sat   <= n_sat;
        r_ocol  <= n_ocol;
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= n_ov;
        end
    end

    assign o_valid         = r_ov;
    assign o_result_value  = r_val;
    assign o_result_column = r_ocol;
    assign o_last_of_run   = r_last;
    assign o_empty_segment = r_empty;
    assign o_saturated     = r_sat;

    // An empty segment never reports saturation.
    a_empty_nosat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_empty_segment |-> !o_saturated)
        else $error("empty segment flagged saturated");

    // Input is never taken while a divide or emission is under way.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV || r_state == ST_OUT) |-> !o_ready)
        else $error("input accepted while busy");

    // A stalled output beat is not overwritten.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_result_column) && $stable(o_result_value))
        else $error("output beat changed while stalled");

endmodule
